// ===== rtl/stereo_mix_gain_pan_unit_assert.svh =====
// ----------------------------------------------------------------------------
// stereo mix assertion macros
// shorthand for the concurrent checks of the mixer top level
// ----------------------------------------------------------------------------
`ifndef STEREO_MIX_GAIN_PAN_UNIT_ASSERT_SVH
`define STEREO_MIX_GAIN_PAN_UNIT_ASSERT_SVH

// same-cycle implication
`define SMGP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smgp: implication check failed");

// next-cycle implication
`define SMGP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smgp: next-cycle check failed");

`endif

// ===== rtl/smgp_pkg.sv =====
// ----------------------------------------------------------------------------
// smgp_pkg
// shared types, codes, and saturating and halving helpers of the stereo mixer
// ----------------------------------------------------------------------------
`default_nettype none

package smgp_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned STORE_W   = 2 * SAMPLE_W;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;

  localparam logic [GAIN_W-1:0] GLOBAL_GAIN_RST = 16'd16384;

  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_GAIN    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_GAIN_EN = 1'b1;

  localparam logic ACT_MIX  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic en;
    logic we;
  } store_ctrl_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [32:0] v);
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    hi = 33'sd32767;
    lo = -33'sd32768;
    if (v > hi) begin
      sat16 = 16'sh7fff;
    end else if (v < lo) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[SAMPLE_W-1:0];
    end
  endfunction

  // halve, truncating toward zero
  function automatic logic signed [SAMPLE_W-1:0] half_tz(
    input logic signed [SAMPLE_W-1:0] a
  );
    logic signed [SAMPLE_W:0] t;
    t = 17'(a) + 17'({16'b0, a[SAMPLE_W-1]});
    half_tz = t[SAMPLE_W:1];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stereo_mix_gain_pan_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_mix_gain_pan_unit
// stereo frame mixer with stream gain, pan and master gain at readout
// ----------------------------------------------------------------------------
// One item at a time through a single-port frame store. A mix item: read
// with stream gain, pan multiply, saturating write-back (skipped when out
// of range). A readout item: read, master gain if enabled and clear, plus
// any wait for the output register to drain. The store read-modify-write
// sets these steps. After reset the store is swept to zero, during which
// no item is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_mix_gain_pan_unit_assert.svh"

module stereo_mix_gain_pan_unit #(
  parameter int unsigned FRAME_PAIRS    = 1024,
  parameter int unsigned GAIN_FRAC_BITS = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 cfg_we_i,
  input  logic [smgp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [smgp_pkg::CFG_W-1:0]           cfg_wdata_i,

  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 action_i,
  input  logic [smgp_pkg::POS_W-1:0]           position_i,
  input  logic signed [smgp_pkg::SAMPLE_W-1:0] left_sample_i,
  input  logic signed [smgp_pkg::SAMPLE_W-1:0] right_sample_i,
  input  logic                                 mono_i,
  input  logic [smgp_pkg::GAIN_W-1:0]          stream_gain_i,
  input  logic [smgp_pkg::GAIN_W-1:0]          left_scale_i,
  input  logic [smgp_pkg::GAIN_W-1:0]          right_scale_i,

  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [smgp_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [smgp_pkg::SAMPLE_W-1:0] right_out_o
);
  import smgp_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_PAIRS);
  localparam int unsigned PW = (AW > POS_W) ? AW : POS_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_WB   = 3'b100
  } state_e;

  state_e st_q, st_d;

  logic [GAIN_W-1:0] gg_q;
  logic              gg_en_q;

  logic              accept;
  logic              clr_busy;
  logic [PW-1:0]     pos_ext;
  logic [AW-1:0]     pos_addr;
  logic              pos_ok;

  logic                       act_q;
  logic                       pos_ok_q;
  logic [AW-1:0]              addr_q;
  logic [GAIN_W-1:0]          lsc_q, rsc_q;
  logic signed [SAMPLE_W-1:0] lg_q, rg_q, lv_q, rv_q;
  logic signed [SAMPLE_W-1:0] lg_d, rg_d;

  logic signed [SAMPLE_W-1:0] r_src;
  logic signed [SAMPLE_W-1:0] m_al, m_ar, m_yl, m_yr;
  logic [GAIN_W-1:0]          m_gl, m_gr;

  store_ctrl_t                st_ctrl;
  logic [AW-1:0]              st_addr;
  logic [STORE_W-1:0]         st_wdata;
  logic [STORE_W-1:0]         st_rdata;
  logic signed [SAMPLE_W-1:0] rd_l, rd_r;
  logic signed [SAMPLE_W:0]   sum_l, sum_r;

  logic                       slot_free;
  logic                       emit;
  logic                       rd_stall;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_l_q, out_r_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gg_q    <= GLOBAL_GAIN_RST;
      gg_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GLOBAL_GAIN:    gg_q    <= cfg_wdata_i;
        REG_GLOBAL_GAIN_EN: gg_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (st_q == ST_IDLE) && !clr_busy;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_ext    = PW'(position_i);
  assign pos_addr   = pos_ext[AW-1:0];
  assign pos_ok     = 32'(position_i) < 32'(FRAME_PAIRS);

  // stream gain on the way in
  assign r_src = mono_i ? left_sample_i : right_sample_i;

  smgp_qmul #(.FRAC_BITS(GAIN_FRAC_BITS)) u_gain_l (
    .a_i (half_tz(left_sample_i)),
    .g_i (stream_gain_i),
    .y_o (lg_d)
  );

  smgp_qmul #(.FRAC_BITS(GAIN_FRAC_BITS)) u_gain_r (
    .a_i (half_tz(r_src)),
    .g_i (stream_gain_i),
    .y_o (rg_d)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= action_i;
      pos_ok_q <= pos_ok;
      addr_q   <= pos_addr;
      lsc_q    <= left_scale_i;
      rsc_q    <= right_scale_i;
      lg_q     <= lg_d;
      rg_q     <= rg_d;
    end
  end

  // shared second multiplier pair: pan for a mix, master gain for a readout
  assign rd_l = st_rdata[SAMPLE_W-1:0];
  assign rd_r = st_rdata[STORE_W-1:SAMPLE_W];
  assign m_al = (act_q == ACT_READ) ? rd_l : lg_q;
  assign m_ar = (act_q == ACT_READ) ? rd_r : rg_q;
  assign m_gl = (act_q == ACT_READ) ? gg_q : lsc_q;
  assign m_gr = (act_q == ACT_READ) ? gg_q : rsc_q;

  smgp_qmul #(.FRAC_BITS(GAIN_FRAC_BITS)) u_mul_l (
    .a_i (m_al),
    .g_i (m_gl),
    .y_o (m_yl)
  );

  smgp_qmul #(.FRAC_BITS(GAIN_FRAC_BITS)) u_mul_r (
    .a_i (m_ar),
    .g_i (m_gr),
    .y_o (m_yr)
  );

  always_ff @(posedge clk_i) begin
    if (st_q == ST_MUL && act_q == ACT_MIX) begin
      lv_q <= m_yl;
      rv_q <= m_yr;
    end
  end

  assign sum_l = 17'(rd_l) + 17'(lv_q);
  assign sum_r = 17'(rd_r) + 17'(rv_q);

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = (st_q == ST_MUL) && (act_q == ACT_READ) && slot_free;
  assign rd_stall  = (st_q == ST_MUL) && (act_q == ACT_READ) && out_valid_q && !out_ready_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (act_q == ACT_MIX) begin
          st_d = pos_ok_q ? ST_WB : ST_IDLE;
        end else if (slot_free) begin
          st_d = ST_IDLE;
        end
      end
      ST_WB:   st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // store port
  always_comb begin
    st_ctrl  = '0;
    st_addr  = addr_q;
    st_wdata = '0;
    if (accept) begin
      st_ctrl.en = 1'b1;
      st_addr    = pos_addr;
    end else if (emit && pos_ok_q) begin
      st_ctrl.en = 1'b1;
      st_ctrl.we = 1'b1;
    end else if (st_q == ST_WB) begin
      st_ctrl.en = 1'b1;
      st_ctrl.we = 1'b1;
      st_wdata   = {sat16(33'(sum_r)), sat16(33'(sum_l))};
    end
  end

  smgp_store #(.DEPTH(FRAME_PAIRS), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (st_ctrl),
    .addr_i  (st_addr),
    .wdata_i (st_wdata),
    .rdata_o (st_rdata),
    .busy_o  (clr_busy)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (!pos_ok_q) begin
        out_l_q <= '0;
        out_r_q <= '0;
      end else if (gg_en_q) begin
        out_l_q <= m_yl;
        out_r_q <= m_yr;
      end else begin
        out_l_q <= rd_l;
        out_r_q <= rd_r;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

  `SMGP_ASSERT_NEXT(a_accept_to_mul, clk_i, rst_ni, accept, st_q == ST_MUL)
  `SMGP_ASSERT_IMPL(a_wb_in_range, clk_i, rst_ni, st_q == ST_WB, pos_ok_q && !clr_busy)
  `SMGP_ASSERT_NEXT(a_hold_read, clk_i, rst_ni, rd_stall, st_q == ST_MUL)

endmodule

`default_nettype wire

// ===== rtl/smgp_qmul.sv =====
// ----------------------------------------------------------------------------
// smgp_qmul
// signed sample times unsigned Q gain, truncated toward zero and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module smgp_qmul #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic signed [smgp_pkg::SAMPLE_W-1:0] a_i,
  input  logic        [smgp_pkg::GAIN_W-1:0]   g_i,
  output logic signed [smgp_pkg::SAMPLE_W-1:0] y_o
);
  import smgp_pkg::*;

  localparam logic signed [32:0] BIAS = (33'sd1 <<< FRAC_BITS) - 33'sd1;

  logic signed [16:0] g_s;
  logic signed [32:0] prod;
  logic signed [32:0] biased;
  logic signed [32:0] shifted;

  assign g_s     = $signed({1'b0, g_i});
  assign prod    = a_i * g_s;
  assign biased  = prod + (prod[32] ? BIAS : 33'sd0);
  assign shifted = biased >>> FRAC_BITS;
  assign y_o     = sat16(shifted);

endmodule

`default_nettype wire

// ===== rtl/smgp_store.sv =====
// ----------------------------------------------------------------------------
// smgp_store
// single-port frame store of sample pairs with a clearing sweep after reset
// ----------------------------------------------------------------------------
`default_nettype none

module smgp_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  smgp_pkg::store_ctrl_t          ctrl_i,
  input  logic [AW-1:0]                  addr_i,
  input  logic [smgp_pkg::STORE_W-1:0]   wdata_i,
  output logic [smgp_pkg::STORE_W-1:0]   rdata_o,
  output logic                           busy_o
);
  import smgp_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [STORE_W-1:0] mem [DEPTH];
  logic [STORE_W-1:0] rdata_q;
  logic [AW-1:0]      clr_cnt_q, clr_cnt_d;
  logic               busy_q, busy_d;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [STORE_W-1:0] wr_data;

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    busy_d    = busy_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      busy_q    <= busy_d;
    end
  end

  assign wr_en   = busy_q || (ctrl_i.en && ctrl_i.we);
  assign wr_addr = busy_q ? clr_cnt_q : addr_i;
  assign wr_data = busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl_i.en && !ctrl_i.we && !busy_q) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire
